FILE: design/rsbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbd_pkg
// Shared types and constants for the run-length sprite blit decoder.
// ----------------------------------------------------------------------------
package rsbd_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEST_HEIGHT = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y    = 8'd3;

    localparam logic [12:0] DEST_WIDTH_RESET  = 13'd320;
    localparam logic [12:0] DEST_HEIGHT_RESET = 13'd200;

    // Largest frame dimension the clipper honors.
    localparam logic [12:0] MAX_DIM = 13'd4096;

    // Control bytes with this bit set skip transparent pixels.
    localparam int SKIP_BIT = 7;

    typedef struct packed {
        logic        [12:0] dest_width;
        logic        [12:0] dest_height;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
    } cfg_t;

endpackage

FILE: design/rle_sprite_blit_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_sprite_blit_decoder
// Decodes a transparent-skip run-length sprite stream into clipped pixel
// writes.
//
//   Channel   Dir  Beat contents (lowest bit first)
//   s_        in   tdata: data_byte[7:0]; tuser: start_req
//   m_        out  tdata: pixel_x[11:0], pixel_y[11:0], pixel_value[7:0];
//                  tuser: write_enable; tlast: last
//   cfg_      in   index 0..3: dest_width, dest_height, origin_x, origin_y
//
// One byte is accepted per cycle while the result register is not stalled;
// a result passes through the input register and then the result register.
// Bytes that produce no write and do not end a sprite give no output beat.
// Reset (aresetn low, synchronous) idles the parser until a start byte.
// A stall on m_tready holds the result; the input register keeps taking a
// byte in the cycle the result is taken.
// ----------------------------------------------------------------------------
module rle_sprite_blit_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte[7:0]
    input  logic [0:0]  s_tuser,    // start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // pixel_x[11:0], pixel_y[23:12], pixel_value[31:24]
    output logic [0:0]  m_tuser,    // write_enable
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [rsbd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rsbd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rsbd_pkg::cfg_t cfg;
    logic        we;
    logic [11:0] px, py;
    logic [7:0]  pv;

    rsbd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rsbd_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_byte   (s_tdata),
        .s_start  (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_we     (we),
        .m_px     (px),
        .m_py     (py),
        .m_pv     (pv),
        .m_last   (m_tlast)
    );

    assign m_tdata = {pv, py, px};
    assign m_tuser = we;

endmodule

FILE: design/rsbd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbd_cfg
// Configuration register file: frame size and sprite origin.
// ----------------------------------------------------------------------------
module rsbd_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rsbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rsbd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rsbd_pkg::cfg_t                     cfg
);

    rsbd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dest_width  <= rsbd_pkg::DEST_WIDTH_RESET;
            cfg_reg.dest_height <= rsbd_pkg::DEST_HEIGHT_RESET;
            cfg_reg.origin_x    <= '0;
            cfg_reg.origin_y    <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                rsbd_pkg::CFG_DEST_WIDTH:  cfg_reg.dest_width  <= cfg_data[12:0];
                rsbd_pkg::CFG_DEST_HEIGHT: cfg_reg.dest_height <= cfg_data[12:0];
                rsbd_pkg::CFG_ORIGIN_X:    cfg_reg.origin_x    <= $signed(cfg_data);
                rsbd_pkg::CFG_ORIGIN_Y:    cfg_reg.origin_y    <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

endmodule

FILE: design/rsbd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsbd_core
// Input register, header/run parser with clipping, and result register.
// ----------------------------------------------------------------------------
module rsbd_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  rsbd_pkg::cfg_t  cfg,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_byte,
    input  logic            s_start,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic            m_we,
    output logic [11:0]     m_px,
    output logic [11:0]     m_py,
    output logic [7:0]      m_pv,
    output logic            m_last
);

    typedef enum logic [2:0] {
        PH_DONE, PH_HDR1, PH_HDR2, PH_HDR3, PH_CTRL, PH_LIT
    } phase_t;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] row_reg, row_next;
    logic [16:0] col_reg, col_next;
    logic [6:0]  lit_reg, lit_next;

    // Result register.
    logic        out_valid_reg;
    logic        we_reg, last_reg;
    logic [11:0] px_reg, py_reg;
    logic [7:0]  pv_reg;

    logic        advance;
    logic        we_next, last_next;
    logic [11:0] px_next, py_next;
    logic [7:0]  pv_next;
    logic        end_chk;
    logic [16:0] col_after;
    logic [6:0]  lit_dec;

    logic signed [18:0] x_pos;
    logic signed [17:0] y_pos;
    logic [12:0]        wlim, hlim;
    logic               in_frame;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Destination position of the current literal and its clip test.
    assign x_pos = {{3{cfg.origin_x[15]}}, cfg.origin_x} + $signed({2'b00, col_reg});
    assign y_pos = {{2{cfg.origin_y[15]}}, cfg.origin_y} + $signed({2'b00, row_reg});
    assign wlim  = (cfg.dest_width  > rsbd_pkg::MAX_DIM) ? rsbd_pkg::MAX_DIM : cfg.dest_width;
    assign hlim  = (cfg.dest_height > rsbd_pkg::MAX_DIM) ? rsbd_pkg::MAX_DIM : cfg.dest_height;
    assign in_frame = !x_pos[18] && !y_pos[17]
                   && (x_pos[17:0] < {5'b0, wlim}) && (y_pos[16:0] < {4'b0, hlim});
    assign lit_dec = lit_reg - 7'd1;

    always_comb begin
        phase_next  = phase_reg;
        width_next  = width_reg;
        height_next = height_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        lit_next    = lit_reg;
        we_next     = 1'b0;
        last_next   = 1'b0;
        px_next     = '0;
        py_next     = '0;
        pv_next     = '0;
        end_chk     = 1'b0;
        col_after   = col_reg;

        if (in_start_reg) begin
            width_next  = {8'h00, in_byte_reg};
            height_next = '0;
            row_next    = '0;
            col_next    = '0;
            lit_next    = '0;
            phase_next  = PH_HDR1;
        end else begin
            case (phase_reg)
                PH_HDR1: begin
                    width_next = {in_byte_reg, width_reg[7:0]};
                    phase_next = PH_HDR2;
                end
                PH_HDR2: begin
                    height_next = {8'h00, in_byte_reg};
                    phase_next  = PH_HDR3;
                end
                PH_HDR3: begin
                    height_next = {in_byte_reg, height_reg[7:0]};
                    row_next    = '0;
                    col_next    = '0;
                    lit_next    = '0;
                    if (width_reg == 16'd0 || height_next == 16'd0) begin
                        phase_next = PH_DONE;
                        last_next  = 1'b1;
                    end else begin
                        phase_next = PH_CTRL;
                    end
                end
                PH_CTRL: begin
                    if (in_byte_reg[rsbd_pkg::SKIP_BIT]) begin
                        col_after = col_reg + {10'b0, in_byte_reg[6:0]};
                        col_next  = col_after;
                        end_chk   = 1'b1;
                    end else if (in_byte_reg != 8'h00) begin
                        lit_next   = in_byte_reg[6:0];
                        phase_next = PH_LIT;
                    end
                end
                PH_LIT: begin
                    // Literals past the row end are consumed but not placed.
                    if (col_reg < {1'b0, width_reg}) begin
                        if (in_frame) begin
                            we_next = 1'b1;
                            px_next = x_pos[11:0];
                            py_next = y_pos[11:0];
                            pv_next = in_byte_reg;
                        end
                        col_after = col_reg + 17'd1;
                    end
                    col_next = col_after;
                    lit_next = lit_dec;
                    if (lit_dec == 7'd0) begin
                        phase_next = PH_CTRL;
                        end_chk    = 1'b1;
                    end
                end
                default: ;
            endcase

            if (end_chk && col_after >= {1'b0, width_reg}) begin
                col_next = '0;
                row_next = row_reg + 16'd1;
                if (row_next >= height_reg) begin
                    phase_next = PH_DONE;
                    last_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_DONE;
            width_reg     <= '0;
            height_reg    <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            lit_reg       <= '0;
            we_reg        <= 1'b0;
            last_reg      <= 1'b0;
            px_reg        <= '0;
            py_reg        <= '0;
            pv_reg        <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= we_next || last_next;
                phase_reg     <= phase_next;
                width_reg     <= width_next;
                height_reg    <= height_next;
                row_reg       <= row_next;
                col_reg       <= col_next;
                lit_reg       <= lit_next;
                we_reg        <= we_next;
                last_reg      <= last_next;
                px_reg        <= px_next;
                py_reg        <= py_next;
                pv_reg        <= pv_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_byte;
            in_start_reg <= s_start;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_we     = we_reg;
    assign m_last   = last_reg;
    assign m_px     = px_reg;
    assign m_py     = py_reg;
    assign m_pv     = pv_reg;

    // A delivered beat always carries a write or the end of a sprite.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (we_reg || last_reg))
        else $error("result beat with neither write nor last");

    // Beats without a write carry zeroed pixel fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !we_reg) |-> (px_reg == 12'd0 && py_reg == 12'd0 && pv_reg == 8'd0))
        else $error("pixel fields not cleared on a non-write beat");

    // A run in progress always has literals left.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LIT) |-> (lit_reg != 7'd0))
        else $error("literal run with no bytes left");

    // Waiting for a control byte, the column lies inside the row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CTRL) |-> (col_reg < {1'b0, width_reg}))
        else $error("column past row end at a control byte");

    // A processed start byte always leads to the second header byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_start_reg) |=> (phase_reg == PH_HDR1))
        else $error("start byte did not restart the header");

endmodule
